@@ sv/quietest_channel_selector_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the quietest channel selector checks
// ---------------------------------------------------------------------------
`ifndef QUIETEST_CHANNEL_SELECTOR_UNIT_ASSERT_SVH
`define QUIETEST_CHANNEL_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define QCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define QCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qcs_pkg.sv @@
// ---------------------------------------------------------------------------
// qcs_pkg
// Shared types, constants and helpers of the quietest channel selector.
// ---------------------------------------------------------------------------
package qcs_pkg;

  localparam int unsigned MaxChannels = 32;
  localparam int unsigned LevelW      = 24;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned FrameW      = 13;
  localparam int unsigned WindowW     = 24;
  localparam int unsigned RemainW     = 25;
  localparam int unsigned MaskW       = 32;
  localparam int unsigned CountW      = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam logic [FrameW-1:0] FrameMax = 13'd4096;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_RECORD_CHANNELS = 3'd0,
    REG_SELECT_COUNT    = 3'd1,
    REG_RELEASE_COEF    = 3'd2,
    REG_FRAME_LENGTH    = 3'd3,
    REG_STABLE_WINDOW   = 3'd4,
    REG_TOTAL_WINDOW    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_SEARCHING = 2'd0,
    STATUS_STABLE    = 2'd1,
    STATUS_TIMEOUT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a sample request
    ST_MUL,    // envelope read back, form release product
    ST_WR,     // write envelope, advance positions
    ST_SCAN,   // scan head slots for the loudest level
    ST_RDI,    // read level of the candidate slot
    ST_CMPI,   // compare candidate against loudest
    ST_MOVE,   // rotate and swap order slots
    ST_MASK,   // capture picked mask
    ST_COUNT,  // count new picks
    ST_EMIT    // update counters, present result
  } state_t;

  // control from sequencer to order file
  typedef struct packed {
    logic move;
    logic [4:0] pos;
    logic [4:0] last;   // slot k-1
    logic [4:0] cand;   // slot i
  } ord_ctl_t;

  function automatic logic [CountW-1:0] popcount32(input logic [MaskW-1:0] v);
    logic [CountW-1:0] c;
    c = '0;
    for (int b = 0; b < MaskW; b++) begin
      c = c + CountW'(v[b]);
    end
    return c;
  endfunction

endpackage

@@ sv/qcs_env_ram.sv @@
// ---------------------------------------------------------------------------
// qcs_env_ram
// Envelope store: one write port, one registered read port, reads zero
// for entries not written since reset.
// ---------------------------------------------------------------------------
module qcs_env_ram #(
  parameter int unsigned Depth = qcs_pkg::MaxChannels,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [AddrW-1:0]            rd_addr,
  output logic [qcs_pkg::LevelW-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [AddrW-1:0]            wr_addr,
  input  logic [qcs_pkg::LevelW-1:0]  wr_data
);

  logic [qcs_pkg::LevelW-1:0] mem [Depth];
  logic [Depth-1:0]           vld_r;
  logic [qcs_pkg::LevelW-1:0] data_r;
  logic                       data_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        data_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = data_vld_r ? data_r : '0;

endmodule

@@ sv/qcs_order_file.sv @@
// ---------------------------------------------------------------------------
// qcs_order_file
// Persistent channel order: one read port, rotate-and-swap move, and the
// mask of channels held in the head slots.
// ---------------------------------------------------------------------------
module qcs_order_file #(
  parameter int unsigned Depth = qcs_pkg::MaxChannels,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [AddrW-1:0]           rd_slot,
  output logic [AddrW-1:0]           rd_chan,
  input  qcs_pkg::ord_ctl_t          ctl,
  input  logic [CntW-1:0]            head_cnt,
  output logic [qcs_pkg::MaskW-1:0]  head_mask
);

  logic [AddrW-1:0] ord_r [Depth];
  logic [AddrW-1:0] pos, last, cand;

  assign pos  = ctl.pos[AddrW-1:0];
  assign last = ctl.last[AddrW-1:0];
  assign cand = ctl.cand[AddrW-1:0];

  assign rd_chan = ord_r[rd_slot];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Depth; j++) begin
        ord_r[j] <= AddrW'(j);
      end
    end else if (ctl.move) begin
      // rotate pos..k-1 left, then swap slot k-1 with the candidate
      for (int j = 0; j < Depth - 1; j++) begin
        if (AddrW'(j) >= pos && AddrW'(j) < last) begin
          ord_r[j] <= ord_r[j+1];
        end
      end
      ord_r[last] <= ord_r[cand];
      ord_r[cand] <= ord_r[pos];
    end
  end

  always_comb begin
    head_mask = '0;
    for (int j = 0; j < Depth; j++) begin
      if (CntW'(j) < head_cnt) begin
        head_mask = head_mask | (qcs_pkg::MaskW'(1) << ord_r[j]);
      end
    end
  end

endmodule

@@ sv/quietest_channel_selector_unit.sv @@
// ---------------------------------------------------------------------------
// quietest_channel_selector_unit
// Per-channel peak envelopes over interleaved samples; at each frame end
// picks the quietest channels and reports selection stability or timeout.
// ---------------------------------------------------------------------------
//  channel | ports                         | moves
//  in      | in_valid/in_ready, in_sample  | one sample request
//  out     | out_valid/out_ready, out_*    | one result per frame
//  cfg     | cfg_valid/cfg_ready, index    | one register write
//
// A sample passes accept with envelope read, release multiply, write-back through
// the envelope RAM port. At a frame end the order walk scans the k head slots for
// each of the n-k later slots (n channels, k picks) over the single RAM read port.
// Reset is synchronous and clears all control state and the envelope valid bits.
// Input stalls while the sequencer is busy; a result still waiting holds the
// next frame end in its emit step, which keeps the input stalled until taken.
// ---------------------------------------------------------------------------
module quietest_channel_selector_unit #(
  parameter int unsigned MaxChannels = qcs_pkg::MaxChannels
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qcs_pkg::SampleW-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [qcs_pkg::CountW-1:0]    out_changed_count,
  output logic [qcs_pkg::MaskW-1:0]     out_selected_mask,
  output logic [qcs_pkg::MaskW-1:0]     out_other_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [qcs_pkg::WindowW-1:0]   cfg_data
);

  localparam int unsigned AddrW = $clog2(MaxChannels);
  localparam int unsigned CntW  = $clog2(MaxChannels + 1);
  localparam int unsigned LvlW  = qcs_pkg::LevelW;
  localparam int unsigned ProdW = qcs_pkg::LevelW + qcs_pkg::CoefW;

  // configuration registers
  logic [5:0]                   rec_ch_r;
  logic [5:0]                   sel_cnt_r;
  logic [qcs_pkg::CoefW-1:0]    coef_r;
  logic [qcs_pkg::FrameW-1:0]   frame_len_r;
  logic [qcs_pkg::WindowW-1:0]  stable_win_r;
  logic [qcs_pkg::WindowW-1:0]  total_win_r;

  // effective limits
  logic [CntW-1:0]              n_eff, k_eff;
  logic [qcs_pkg::FrameW-1:0]   fl_eff;
  logic [qcs_pkg::RemainW-1:0]  stable_load, total_load;

  // control state
  qcs_pkg::state_t              state_r, state_nxt;
  logic [AddrW-1:0]             ch_pos_r;
  logic [11:0]                  fr_pos_r;
  logic                         finished_r;
  logic [qcs_pkg::MaskW-1:0]    prev_mask_r;
  logic [qcs_pkg::RemainW-1:0]  stable_rem_r, total_rem_r;

  // sample datapath
  logic [qcs_pkg::SampleW-1:0]  mag;
  logic [LvlW-1:0]              s8_r;
  logic                         attack_r;
  logic [ProdW-1:0]             prod_r;
  logic [LvlW-1:0]              env_new;

  // sort walk
  logic [CntW-1:0]              sort_i_r;
  logic [AddrW-1:0]             scan_slot_r;
  logic                         scan_issue_r;
  logic                         cmp_vld_r;
  logic [AddrW-1:0]             cmp_slot_r;
  logic                         first_r;
  logic [LvlW-1:0]              best_r;
  logic [AddrW-1:0]             pos_r;
  logic                         do_move_r;
  logic [qcs_pkg::MaskW-1:0]    picked_r;
  logic [qcs_pkg::CountW-1:0]   chg_r;

  // result register
  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [qcs_pkg::CountW-1:0]   out_chg_r;
  logic [qcs_pkg::MaskW-1:0]    out_sel_r, out_oth_r;

  // memory hookup
  logic                         env_rd_en, env_wr_en;
  logic [AddrW-1:0]             env_rd_addr;
  logic [LvlW-1:0]              env_rd_data;
  logic [AddrW-1:0]             ord_rd_slot, ord_rd_chan;
  logic [qcs_pkg::MaskW-1:0]    head_mask;
  qcs_pkg::ord_ctl_t            ord_ctl;

  logic                         in_acc, cfg_acc, emit_go;
  logic [AddrW:0]               ch_next;
  logic [12:0]                  fr_next;
  logic                         frame_end;
  logic [AddrW-1:0]             k_last, cand_slot;
  logic [qcs_pkg::RemainW-1:0]  stable_dec, total_dec;
  logic [qcs_pkg::MaskW-1:0]    below_mask;
  logic [qcs_pkg::MaskW:0]      below_wide;

  // -------------------------------------------------------------------------
  // Effective limits: clamp out-of-range register values
  // -------------------------------------------------------------------------
  always_comb begin
    if (rec_ch_r == '0) begin
      n_eff = CntW'(1);
    end else if (32'(rec_ch_r) > MaxChannels) begin
      n_eff = CntW'(MaxChannels);
    end else begin
      n_eff = CntW'(rec_ch_r);
    end
    if (sel_cnt_r == '0) begin
      k_eff = CntW'(1);
    end else if (7'(sel_cnt_r) > 7'(n_eff)) begin
      k_eff = n_eff;
    end else begin
      k_eff = CntW'(sel_cnt_r);
    end
    if (frame_len_r == '0) begin
      fl_eff = qcs_pkg::FrameW'(1);
    end else if (frame_len_r > qcs_pkg::FrameMax) begin
      fl_eff = qcs_pkg::FrameMax;
    end else begin
      fl_eff = frame_len_r;
    end
  end

  assign stable_load = (stable_win_r == '0) ? qcs_pkg::RemainW'(1)
                                            : qcs_pkg::RemainW'(stable_win_r);
  assign total_load  = (total_win_r == '0) ? qcs_pkg::RemainW'(1)
                                           : qcs_pkg::RemainW'(total_win_r);

  assign k_last    = AddrW'(k_eff - CntW'(1));
  assign cand_slot = sort_i_r[AddrW-1:0];

  // -------------------------------------------------------------------------
  // Handshakes
  // -------------------------------------------------------------------------
  assign in_ready  = (state_r == qcs_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  // hold the emit step while the previous result is still waiting
  assign emit_go   = !out_valid_r || out_ready;

  // magnitude |2x+1| without a negate: invert for negative samples
  assign mag = {in_sample[qcs_pkg::SampleW-2:0] ^ {(qcs_pkg::SampleW-1){in_sample[qcs_pkg::SampleW-1]}},
                1'b1};

  assign ch_next   = {1'b0, ch_pos_r} + (AddrW+1)'(1);
  assign fr_next   = {1'b0, fr_pos_r} + 13'd1;
  assign frame_end = (CntW'(ch_next) >= n_eff) && (fr_next >= fl_eff);

  assign env_new = attack_r ? s8_r : s8_r + prod_r[ProdW-1:qcs_pkg::CoefW];

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qcs_pkg::ST_IDLE: begin
        if (in_acc && !finished_r) begin
          state_nxt = qcs_pkg::ST_MUL;
        end
      end
      qcs_pkg::ST_MUL: state_nxt = qcs_pkg::ST_WR;
      qcs_pkg::ST_WR: begin
        if (!frame_end) begin
          state_nxt = qcs_pkg::ST_IDLE;
        end else if (k_eff >= n_eff) begin
          state_nxt = qcs_pkg::ST_MASK;
        end else begin
          state_nxt = qcs_pkg::ST_SCAN;
        end
      end
      qcs_pkg::ST_SCAN: begin
        if (!scan_issue_r && cmp_vld_r) begin
          state_nxt = qcs_pkg::ST_RDI;
        end
      end
      qcs_pkg::ST_RDI:  state_nxt = qcs_pkg::ST_CMPI;
      qcs_pkg::ST_CMPI: state_nxt = qcs_pkg::ST_MOVE;
      qcs_pkg::ST_MOVE: begin
        if (sort_i_r + CntW'(1) >= n_eff) begin
          state_nxt = qcs_pkg::ST_MASK;
        end else begin
          state_nxt = qcs_pkg::ST_SCAN;
        end
      end
      qcs_pkg::ST_MASK:  state_nxt = qcs_pkg::ST_COUNT;
      qcs_pkg::ST_COUNT: state_nxt = qcs_pkg::ST_EMIT;
      qcs_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = qcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qcs_pkg::ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Memory and order-file control
  // -------------------------------------------------------------------------
  always_comb begin
    env_rd_en    = 1'b0;
    env_rd_addr  = ch_pos_r;
    env_wr_en    = 1'b0;
    ord_rd_slot  = cand_slot;
    ord_ctl      = '0;
    ord_ctl.pos  = 5'(pos_r);
    ord_ctl.last = 5'(k_last);
    ord_ctl.cand = 5'(cand_slot);
    unique case (state_r)
      qcs_pkg::ST_IDLE: begin
        env_rd_en = in_acc && !finished_r;
      end
      qcs_pkg::ST_WR: begin
        env_wr_en = 1'b1;
      end
      qcs_pkg::ST_SCAN: begin
        ord_rd_slot = scan_slot_r;
        env_rd_en   = scan_issue_r;
        env_rd_addr = ord_rd_chan;
      end
      qcs_pkg::ST_RDI: begin
        env_rd_en   = 1'b1;
        env_rd_addr = ord_rd_chan;
      end
      qcs_pkg::ST_MOVE: begin
        ord_ctl.move = do_move_r;
      end
      default: begin
      end
    endcase
  end

  qcs_env_ram #(
    .Depth (MaxChannels)
  ) u_env_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (env_rd_en),
    .rd_addr (env_rd_addr),
    .rd_data (env_rd_data),
    .wr_en   (env_wr_en),
    .wr_addr (ch_pos_r),
    .wr_data (env_new)
  );

  qcs_order_file #(
    .Depth (MaxChannels)
  ) u_order_file (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_slot   (ord_rd_slot),
    .rd_chan   (ord_rd_chan),
    .ctl       (ord_ctl),
    .head_cnt  (k_eff),
    .head_mask (head_mask)
  );

  // -------------------------------------------------------------------------
  // Datapath registers without reset
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      qcs_pkg::ST_IDLE: begin
        s8_r <= {mag, 8'd0};
      end
      qcs_pkg::ST_MUL: begin
        // attack on a strictly louder sample, else decay toward it
        attack_r <= (s8_r > env_rd_data);
        prod_r   <= ProdW'(env_rd_data - s8_r) * ProdW'(coef_r);
      end
      qcs_pkg::ST_SCAN: begin
        if (cmp_vld_r && (first_r || env_rd_data > best_r)) begin
          best_r <= env_rd_data;
          pos_r  <= cmp_slot_r;
        end
        cmp_slot_r <= scan_slot_r;
      end
      qcs_pkg::ST_CMPI: begin
        do_move_r <= (best_r > env_rd_data);
      end
      qcs_pkg::ST_MASK: begin
        picked_r <= head_mask;
      end
      qcs_pkg::ST_COUNT: begin
        chg_r <= qcs_pkg::popcount32(picked_r & ~prev_mask_r);
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  assign stable_dec = (stable_rem_r > qcs_pkg::RemainW'(fl_eff))
                      ? stable_rem_r - qcs_pkg::RemainW'(fl_eff) : '0;
  assign total_dec  = (total_rem_r > qcs_pkg::RemainW'(fl_eff))
                      ? total_rem_r - qcs_pkg::RemainW'(fl_eff) : '0;
  assign below_wide = ((qcs_pkg::MaskW+1)'(1) << n_eff) - (qcs_pkg::MaskW+1)'(1);
  assign below_mask = below_wide[qcs_pkg::MaskW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qcs_pkg::ST_IDLE;
      rec_ch_r     <= 6'd2;
      sel_cnt_r    <= 6'd1;
      coef_r       <= 16'd65000;
      frame_len_r  <= 13'd256;
      stable_win_r <= 24'd48000;
      total_win_r  <= 24'd480000;
      stable_rem_r <= 25'd48000;
      total_rem_r  <= 25'd480000;
      ch_pos_r     <= '0;
      fr_pos_r     <= '0;
      finished_r   <= 1'b0;
      prev_mask_r  <= '0;
      sort_i_r     <= '0;
      scan_slot_r  <= '0;
      scan_issue_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      first_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= qcs_pkg::STATUS_SEARCHING;
      out_chg_r    <= '0;
      out_sel_r    <= '0;
      out_oth_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // drop a taken result unless the emit step loads the next one
      if (out_valid_r && out_ready && (state_r != qcs_pkg::ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_acc) begin
        unique case (cfg_index)
          qcs_pkg::REG_RECORD_CHANNELS: rec_ch_r    <= cfg_data[5:0];
          qcs_pkg::REG_SELECT_COUNT:    sel_cnt_r   <= cfg_data[5:0];
          qcs_pkg::REG_RELEASE_COEF:    coef_r      <= cfg_data[15:0];
          qcs_pkg::REG_FRAME_LENGTH:    frame_len_r <= cfg_data[12:0];
          qcs_pkg::REG_STABLE_WINDOW: begin
            stable_win_r <= cfg_data;
            stable_rem_r <= (cfg_data == '0) ? qcs_pkg::RemainW'(1)
                                             : qcs_pkg::RemainW'(cfg_data);
          end
          qcs_pkg::REG_TOTAL_WINDOW: begin
            total_win_r <= cfg_data;
            total_rem_r <= (cfg_data == '0) ? qcs_pkg::RemainW'(1)
                                            : qcs_pkg::RemainW'(cfg_data);
          end
          default: begin
          end
        endcase
      end

      unique case (state_r)
        qcs_pkg::ST_WR: begin
          // advance positions; wrap when beyond a shrunk limit
          if (CntW'(ch_next) >= n_eff) begin
            ch_pos_r <= '0;
            fr_pos_r <= (fr_next >= fl_eff) ? 12'd0 : fr_next[11:0];
          end else begin
            ch_pos_r <= ch_next[AddrW-1:0];
          end
          sort_i_r     <= k_eff;
          scan_slot_r  <= k_last;
          scan_issue_r <= 1'b1;
          cmp_vld_r    <= 1'b0;
          first_r      <= 1'b1;
        end
        qcs_pkg::ST_SCAN: begin
          cmp_vld_r <= scan_issue_r;
          if (scan_issue_r) begin
            if (scan_slot_r == '0) begin
              scan_issue_r <= 1'b0;
            end else begin
              scan_slot_r <= scan_slot_r - AddrW'(1);
            end
          end
          if (cmp_vld_r) begin
            first_r <= 1'b0;
          end
        end
        qcs_pkg::ST_MOVE: begin
          // next candidate slot, restart the head scan
          sort_i_r     <= sort_i_r + CntW'(1);
          scan_slot_r  <= k_last;
          scan_issue_r <= 1'b1;
          cmp_vld_r    <= 1'b0;
          first_r      <= 1'b1;
        end
        qcs_pkg::ST_EMIT: begin
          if (emit_go) begin
            logic [qcs_pkg::MaskW-1:0]   sel;
            logic [qcs_pkg::RemainW-1:0] st_rem;
            logic [1:0]                  stat;
            sel    = (chg_r != '0) ? picked_r : prev_mask_r;
            st_rem = (chg_r != '0) ? stable_load : stable_dec;
            if (total_dec == '0) begin
              stat = qcs_pkg::STATUS_TIMEOUT;
            end else if (st_rem == '0) begin
              stat = qcs_pkg::STATUS_STABLE;
            end else begin
              stat = qcs_pkg::STATUS_SEARCHING;
            end
            prev_mask_r  <= sel;
            stable_rem_r <= st_rem;
            total_rem_r  <= total_dec;
            finished_r   <= (stat != qcs_pkg::STATUS_SEARCHING);
            out_valid_r  <= 1'b1;
            out_status_r <= stat;
            out_chg_r    <= chg_r;
            out_sel_r    <= sel;
            out_oth_r    <= below_mask & ~sel;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_changed_count = out_chg_r;
  assign out_selected_mask = out_sel_r;
  assign out_other_mask    = out_oth_r;

endmodule

@@ sv/qcs_checker.sv @@
// ---------------------------------------------------------------------------
// qcs_checker
// Port-level checks of the quietest channel selector result channel.
// ---------------------------------------------------------------------------
`include "quietest_channel_selector_unit_assert.svh"

module qcs_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [5:0]  out_changed_count,
  input logic [31:0] out_selected_mask,
  input logic [31:0] out_other_mask
);

  `QCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QCS_ASSERT_NOW(a_masks_apart, out_valid, (out_selected_mask & out_other_mask) == 32'd0, "masks overlap")
  `QCS_ASSERT_NOW(a_chg_fits, out_valid, out_changed_count <= 6'd32 && out_status <= qcs_pkg::STATUS_TIMEOUT, "bad result fields")
  `QCS_ASSERT_NEXT(a_done_quiet, out_valid && out_ready && out_status != qcs_pkg::STATUS_SEARCHING, !out_valid, "result after finish")

endmodule

bind quietest_channel_selector_unit qcs_port_checker u_qcs_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_changed_count (out_changed_count),
  .out_selected_mask (out_selected_mask),
  .out_other_mask    (out_other_mask)
);
